### design/xalu_pkg.sv
// Shared types, codes and helper functions of the x86 integer ALU.
// Used by every module of the block; depends on nothing else.
package xalu_pkg;

   // Operation codes carried on the request tuser
   localparam logic [3:0] OP_ADD   = 4'd0;
   localparam logic [3:0] OP_SUB   = 4'd1;
   localparam logic [3:0] OP_CMP   = 4'd2;
   localparam logic [3:0] OP_INC   = 4'd3;
   localparam logic [3:0] OP_DEC   = 4'd4;
   localparam logic [3:0] OP_NEG   = 4'd5;
   localparam logic [3:0] OP_ADC   = 4'd6;
   localparam logic [3:0] OP_SBB   = 4'd7;
   localparam logic [3:0] OP_MUL   = 4'd8;
   localparam logic [3:0] OP_IMUL1 = 4'd9;
   localparam logic [3:0] OP_IMUL2 = 4'd10;
   localparam logic [3:0] OP_IMUL3 = 4'd11;
   localparam logic [3:0] OP_DIV   = 4'd12;
   localparam logic [3:0] OP_IDIV  = 4'd13;

   // Write targets
   localparam logic [1:0] TGT_NONE = 2'd0;
   localparam logic [1:0] TGT_DEST = 2'd1;
   localparam logic [1:0] TGT_ACC  = 2'd2;

   // Flag bits, same order in the flag vector and the update mask
   localparam logic [3:0] F_CF  = 4'b0001;
   localparam logic [3:0] F_OF  = 4'b0010;
   localparam logic [3:0] F_ZF  = 4'b0100;
   localparam logic [3:0] F_SF  = 4'b1000;
   localparam logic [3:0] F_ALL = 4'b1111;

   // Number of one-bit division steps in the back end
   localparam int DIV_STEPS = 32;

   typedef enum logic [1:0] {KIND_NONE, KIND_ALU, KIND_MUL, KIND_DIV} kind_type;
   typedef enum logic [1:0] {SZ_BYTE, SZ_WORD, SZ_DWORD} size_type;

   // Classified request, as held in the queue
   typedef struct packed {
      kind_type    kind;
      size_type    size;
      logic        sgn;
      logic        one_dest;
      logic [31:0] alu_lo;
      logic [1:0]  alu_tgt;
      logic [3:0]  flags;
      logic [3:0]  fm;
      logic [32:0] op_a;
      logic [32:0] op_b;
      logic [31:0] rem0;
      logic [31:0] low;
      logic [31:0] dvs;
      logic        nd;
      logic        ns;
      logic        err;
   } qent_type;

   // Work carried along the back-end pipeline
   typedef struct packed {
      kind_type    kind;
      size_type    size;
      logic        sgn;
      logic        one_dest;
      logic [31:0] lo;
      logic [31:0] hi;
      logic [31:0] dvs;
      logic        nd;
      logic        ns;
      logic        err;
      logic [1:0]  tgt;
      logic [3:0]  flags;
      logic [3:0]  fm;
   } bst_type;

   // Finished response
   typedef struct packed {
      logic        derr;
      logic [3:0]  fm;
      logic [3:0]  flags;
      logic [1:0]  tgt;
      logic [31:0] hi;
      logic [31:0] lo;
   } rsp_type;

   // Size code to operand size; the unused code counts as dword
   function automatic size_type to_size(input logic [1:0] code);
      size_type s;
      case (code)
         2'd0:    s = SZ_BYTE;
         2'd1:    s = SZ_WORD;
         default: s = SZ_DWORD;
      endcase
      return s;
   endfunction

   // Takes the low bits of the given size and extends them to 33 bits
   function automatic logic [32:0] ext33(input logic [31:0] v, input size_type sz,
                                         input logic sgn);
      logic [32:0] r;
      case (sz)
         SZ_BYTE: r = {{25{sgn & v[7]}}, v[7:0]};
         SZ_WORD: r = {{17{sgn & v[15]}}, v[15:0]};
         default: r = {sgn & v[31], v};
      endcase
      return r;
   endfunction

   // Same extension, kept to 32 bits
   function automatic logic [31:0] ext32(input logic [31:0] v, input size_type sz,
                                         input logic sgn);
      logic [32:0] r;
      r = ext33(v, sz, sgn);
      return r[31:0];
   endfunction

   // Most significant bit at the given size
   function automatic logic msb_at(input logic [31:0] v, input size_type sz);
      logic b;
      case (sz)
         SZ_BYTE: b = v[7];
         SZ_WORD: b = v[15];
         default: b = v[31];
      endcase
      return b;
   endfunction

endpackage

### design/xalu_front.sv
// Front end of the x86 ALU: unpacks a request and classifies it.
// Add/sub class work finishes here; multiply and divide operands are prepared.
// Depends on xalu_pkg.
module xalu_front (
   input  logic [7:0]         req_tuser,   // opcode[3:0], zero fill
   input  logic [167:0]       req_tdata,   // op_size, src_size, dest_value, src_value,
                                           // src2_value, acc_low, acc_high, carry_in
   output xalu_pkg::qent_type ent
);
   import xalu_pkg::*;

   logic [3:0]  opcode;
   size_type    sz;
   size_type    ssz;
   logic [31:0] dest_value, src_value, src2_value, acc_low, acc_high;
   logic        carry_in;

   logic [31:0] dst, src;
   logic [31:0] a, b;
   logic        cin, is_sub;
   logic [32:0] sum33, dif33;
   logic [31:0] res;
   logic        cf, of;

   logic [31:0] dh, dl, dvs_abs, ah;
   logic [63:0] dvd, dvd_neg, dvd_abs;
   logic        nd, ns;

   // Field unpacking
   assign opcode     = req_tuser[3:0];
   assign sz         = to_size(req_tdata[1:0]);
   assign ssz        = to_size(req_tdata[3:2]);
   assign dest_value = req_tdata[35:4];
   assign src_value  = req_tdata[67:36];
   assign src2_value = req_tdata[99:68];
   assign acc_low    = req_tdata[131:100];
   assign acc_high   = req_tdata[163:132];
   assign carry_in   = req_tdata[164];

   // Operands at the operand width; the source is sign-extended first
   assign dst = ext32(dest_value, sz, 1'b0);
   assign src = ext32(ext32(src_value, ssz, 1'b1), sz, 1'b0);

   // Adder operand selection
   always_comb begin
      a      = dst;
      b      = src;
      cin    = 1'b0;
      is_sub = 1'b0;
      unique case (opcode)
         OP_ADD: ;
         OP_SUB, OP_CMP: is_sub = 1'b1;
         OP_INC: b = 32'd1;
         OP_DEC: begin
            b      = 32'd1;
            is_sub = 1'b1;
         end
         OP_NEG: begin
            a      = 32'd0;
            b      = dst;
            is_sub = 1'b1;
         end
         OP_ADC: cin = carry_in;
         OP_SBB: begin
            cin    = carry_in;
            is_sub = 1'b1;
         end
         default: ;
      endcase
   end

   // Add and subtract with flags at the operand width
   assign sum33 = {1'b0, a} + {1'b0, b} + {32'd0, cin};
   assign dif33 = {1'b0, a} - {1'b0, b} - {32'd0, cin};
   assign res   = ext32(is_sub ? dif33[31:0] : sum33[31:0], sz, 1'b0);

   always_comb begin
      case (sz)
         SZ_BYTE: cf = is_sub ? dif33[32] : sum33[8];
         SZ_WORD: cf = is_sub ? dif33[32] : sum33[16];
         default: cf = is_sub ? dif33[32] : sum33[32];
      endcase
      of = is_sub ? msb_at((a ^ b) & (a ^ res), sz) : msb_at(~(a ^ b) & (a ^ res), sz);
   end

   // Divide operand preparation: dividend halves, magnitudes and early error
   always_comb begin
      dh = (sz == SZ_BYTE) ? {24'd0, acc_low[15:8]} : ext32(acc_high, sz, 1'b0);
      dl = ext32(acc_low, sz, 1'b0);
      case (sz)
         SZ_BYTE: dvd = {48'd0, dh[7:0], dl[7:0]};
         SZ_WORD: dvd = {32'd0, dh[15:0], dl[15:0]};
         default: dvd = {dh, dl};
      endcase
      dvd_neg = 64'd0 - dvd;
      case (sz)
         SZ_BYTE: dvd_neg = {48'd0, dvd_neg[15:0]};
         SZ_WORD: dvd_neg = {32'd0, dvd_neg[31:0]};
         default: ;
      endcase
      nd      = (opcode == OP_IDIV) && msb_at(dh, sz);
      ns      = (opcode == OP_IDIV) && msb_at(dst, sz);
      dvd_abs = nd ? dvd_neg : dvd;
      dvs_abs = ns ? ext32(32'd0 - dst, sz, 1'b0) : dst;
      case (sz)
         SZ_BYTE: ah = {24'd0, dvd_abs[15:8]};
         SZ_WORD: ah = {16'd0, dvd_abs[31:16]};
         default: ah = dvd_abs[63:32];
      endcase
   end

   // Queue entry
   always_comb begin
      ent          = '0;
      ent.size     = sz;
      ent.alu_lo   = res;
      ent.flags    = {msb_at(res, sz), (res == 32'd0), of, cf};
      ent.rem0     = dvd_abs[63:32];
      ent.low      = dvd_abs[31:0];
      ent.dvs      = dvs_abs;
      ent.nd       = nd;
      ent.ns       = ns;
      ent.err      = (dvs_abs == 32'd0) || (ah >= dvs_abs);
      ent.sgn      = (opcode != OP_MUL) && (opcode != OP_DIV);
      unique case (opcode)
         OP_ADD, OP_SUB, OP_NEG, OP_ADC, OP_SBB: begin
            ent.kind    = KIND_ALU;
            ent.alu_tgt = TGT_DEST;
            ent.fm      = F_ALL;
         end
         OP_CMP: begin
            ent.kind    = KIND_ALU;
            ent.alu_tgt = TGT_NONE;
            ent.fm      = F_ALL;
         end
         OP_INC, OP_DEC: begin
            ent.kind    = KIND_ALU;
            ent.alu_tgt = TGT_DEST;
            ent.fm      = F_OF | F_ZF | F_SF;
         end
         OP_MUL: begin
            ent.kind = KIND_MUL;
            ent.op_a = ext33(dst, sz, 1'b0);
            ent.op_b = ext33(acc_low, sz, 1'b0);
         end
         OP_IMUL1: begin
            ent.kind = KIND_MUL;
            ent.op_a = ext33(dst, sz, 1'b1);
            ent.op_b = ext33(acc_low, sz, 1'b1);
         end
         OP_IMUL2: begin
            ent.kind     = KIND_MUL;
            ent.one_dest = 1'b1;
            ent.op_a     = ext33(dst, sz, 1'b1);
            ent.op_b     = ext33(src, sz, 1'b1);
         end
         OP_IMUL3: begin
            ent.kind     = KIND_MUL;
            ent.one_dest = 1'b1;
            ent.op_a     = ext33(src_value, sz, 1'b1);
            ent.op_b     = ext33(ext32(src2_value, ssz, 1'b1), sz, 1'b1);
         end
         OP_DIV, OP_IDIV: ent.kind = KIND_DIV;
         default: ent.kind = KIND_NONE;
      endcase
   end

endmodule

### design/xalu_queue.sv
// Short first-in first-out queue between the front and back ends.
// Holds classified requests; depends on xalu_pkg.
module xalu_queue #(
   parameter int DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  xalu_pkg::qent_type push_data,
   output logic               full,
   input  logic               pop,
   output logic               empty,
   output xalu_pkg::qent_type pop_data
);
   import xalu_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   qent_type       mem_ff [DEPTH];
   logic [PW-1:0]  wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic           do_push, do_pop;

   assign full     = (cnt_ff == CW'(DEPTH));
   assign empty    = (cnt_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rptr_ff];

   // Pointer and count update
   always_comb begin
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      cnt_in  = cnt_ff;
      if (do_push) begin
         wptr_in = (wptr_ff == PW'(DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
      end
      if (do_pop) begin
         rptr_in = (rptr_ff == PW'(DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wptr_ff] <= push_data;
      end
   end

   // The fill count never exceeds the depth and holds while full unless an entry is popped
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(DEPTH))
      else $error("queue count beyond depth");
   a_push_full: assert property (@(posedge clock) disable iff (reset)
      full |=> (cnt_ff == CW'(DEPTH)) || $past(do_pop))
      else $error("queue lost an entry while full");

endmodule

### design/xalu_back.sv
// Back end of the x86 ALU: multiply stage, pipelined restoring divider and
// response register with final flag and sign fix-up. Depends on xalu_pkg.
module xalu_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_empty,
   input  xalu_pkg::qent_type  q_data,
   output logic                q_pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output xalu_pkg::rsp_type   rsp
);
   import xalu_pkg::*;

   bst_type     st_ff  [DIV_STEPS + 1];
   bst_type     st_in  [DIV_STEPS + 1];
   logic        vld_ff [DIV_STEPS + 1];
   logic        adv;
   logic [65:0] prod;

   rsp_type     rsp_ff, rsp_in;
   logic        rsp_vld_ff;

   bst_type     fin;
   logic [63:0] p;
   logic [31:0] m_lo, m_hi, q_mag, q_lim, q_out, r_out;
   logic        m_fit, q_neg, q_ovf;

   // The whole pipeline moves when the response register can take a result
   assign adv   = !rsp_vld_ff || rsp_ready;
   assign q_pop = adv && !q_empty;

   // One restoring division step: one quotient bit per stage
   function automatic bst_type div_step(input bst_type s);
      bst_type     r;
      logic [32:0] t;
      logic [32:0] d;
      r = s;
      t = {s.hi, s.lo[31]};
      d = t - {1'b0, s.dvs};
      if (s.kind == KIND_DIV) begin
         if (t >= {1'b0, s.dvs}) begin
            r.hi = d[31:0];
            r.lo = {s.lo[30:0], 1'b1};
         end else begin
            r.hi = t[31:0];
            r.lo = {s.lo[30:0], 1'b0};
         end
      end
      return r;
   endfunction

   // Multiply stage entry
   assign prod = $signed(q_data.op_a) * $signed(q_data.op_b);

   always_comb begin
      st_in[0]          = '0;
      st_in[0].kind     = q_data.kind;
      st_in[0].size     = q_data.size;
      st_in[0].sgn      = q_data.sgn;
      st_in[0].one_dest = q_data.one_dest;
      st_in[0].dvs      = q_data.dvs;
      st_in[0].nd       = q_data.nd;
      st_in[0].ns       = q_data.ns;
      st_in[0].err      = q_data.err;
      st_in[0].tgt      = q_data.alu_tgt;
      st_in[0].flags    = q_data.flags;
      st_in[0].fm       = q_data.fm;
      case (q_data.kind)
         KIND_MUL: begin
            st_in[0].lo = prod[31:0];
            st_in[0].hi = prod[63:32];
         end
         KIND_DIV: begin
            st_in[0].lo = q_data.low;
            st_in[0].hi = q_data.rem0;
         end
         default: st_in[0].lo = q_data.alu_lo;
      endcase
      for (int i = 1; i <= DIV_STEPS; i++) begin
         st_in[i] = div_step(st_ff[i-1]);
      end
   end

   // Pipeline registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= DIV_STEPS; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else if (adv) begin
         vld_ff[0] <= !q_empty;
         for (int i = 1; i <= DIV_STEPS; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i <= DIV_STEPS; i++) begin
            st_ff[i] <= st_in[i];
         end
      end
   end

   // Final fix-up: product split and overflow, quotient sign and range
   assign fin = st_ff[DIV_STEPS];
   assign p   = {fin.hi, fin.lo};

   always_comb begin
      case (fin.size)
         SZ_BYTE: begin
            m_lo  = {24'd0, p[7:0]};
            m_hi  = {24'd0, p[15:8]};
            m_fit = fin.sgn ? ((p[15:7] == '0) || (p[15:7] == '1)) : (p[15:8] == '0);
            q_lim = 32'h0000_0080;
         end
         SZ_WORD: begin
            m_lo  = {16'd0, p[15:0]};
            m_hi  = {16'd0, p[31:16]};
            m_fit = fin.sgn ? ((p[31:15] == '0) || (p[31:15] == '1)) : (p[31:16] == '0);
            q_lim = 32'h0000_8000;
         end
         default: begin
            m_lo  = p[31:0];
            m_hi  = p[63:32];
            m_fit = fin.sgn ? ((p[63:31] == '0) || (p[63:31] == '1)) : (p[63:32] == '0);
            q_lim = 32'h8000_0000;
         end
      endcase
      q_mag = fin.lo;
      q_neg = fin.nd ^ fin.ns;
      q_ovf = fin.sgn && (q_neg ? (q_mag > q_lim) : (q_mag >= q_lim));
      q_out = ext32(q_neg ? 32'd0 - q_mag : q_mag, fin.size, 1'b0);
      r_out = ext32(fin.nd ? 32'd0 - fin.hi : fin.hi, fin.size, 1'b0);
   end

   always_comb begin
      rsp_in = '0;
      case (fin.kind)
         KIND_ALU: begin
            rsp_in.lo    = fin.lo;
            rsp_in.tgt   = fin.tgt;
            rsp_in.fm    = fin.fm;
            rsp_in.flags = fin.flags & fin.fm;
         end
         KIND_MUL: begin
            rsp_in.lo    = m_lo;
            rsp_in.hi    = fin.one_dest ? 32'd0 : m_hi;
            rsp_in.tgt   = fin.one_dest ? TGT_DEST : TGT_ACC;
            rsp_in.fm    = F_CF | F_OF;
            rsp_in.flags = m_fit ? 4'd0 : (F_CF | F_OF);
         end
         KIND_DIV: begin
            if (fin.err || q_ovf) begin
               rsp_in.derr = 1'b1;
            end else begin
               rsp_in.lo  = q_out;
               rsp_in.hi  = r_out;
               rsp_in.tgt = TGT_ACC;
            end
         end
         default: ;
      endcase
   end

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (adv) begin
         rsp_vld_ff <= vld_ff[DIV_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp       = rsp_ff;

   // A divide error writes nothing and updates no flags
   a_derr_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && rsp_ff.derr |-> (rsp_ff.tgt == TGT_NONE) && (rsp_ff.fm == 4'd0))
      else $error("divide error with a write or flag update");
   // Flags outside the update mask read as zero
   a_flag_mask: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |-> ((rsp_ff.flags & ~rsp_ff.fm) == 4'd0))
      else $error("flag reported outside the update mask");
   // Items move one stage per advance and none appear from nowhere
   a_stage_move: assert property (@(posedge clock) disable iff (reset)
      adv |=> (vld_ff[1] == $past(vld_ff[0])))
      else $error("pipeline valid did not move with the stage");
   // Stalled pipeline holds its last stage
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(vld_ff[DIV_STEPS]) && rsp_vld_ff)
      else $error("pipeline moved during a stall");

endmodule

### design/x86_integer_alu_with_flags.sv
// Top level of the x86 integer ALU with flags.
// Instantiates xalu_front, xalu_queue and xalu_back; depends on xalu_pkg.
//
// Usage:
// Requests arrive on the req_ stream: req_tuser carries the opcode and req_tdata
// the operand sizes, the operands, the accumulator pair and the incoming carry.
// Each request gives exactly one response on the rsp_ stream, in order, with the
// result value(s), the write target, CF/OF/ZF/SF, the flag update mask and the
// divide error indication.
// Every operation takes the same path from request acceptance to response
// valid: the queue entry is written at acceptance, then one multiply stage,
// 32 divider stages of one quotient bit each and the response register follow.
// Throughput is one request per cycle unless the response side stalls; the single
// multiply stage and the divider stages each take a new item on every advance.
// While a response waits with rsp_tready low, the response register holds, the
// pipeline behind it stops, and the front queue fills; req_tready drops only
// when the queue is full. Synchronous reset empties the queue and clears every
// pipeline valid bit; no response is pending after reset.
module x86_integer_alu_with_flags #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tuser,   // opcode[3:0], zero fill
   input  logic [167:0] req_tdata,   // op_size[1:0], src_size[3:2], dest_value[35:4],
                                     // src_value[67:36], src2_value[99:68],
                                     // acc_low[131:100], acc_high[163:132],
                                     // carry_in[164], zero fill
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [79:0]  rsp_tdata    // result_low[31:0], result_high[63:32],
                                     // write_target[65:64], carry_flag[66],
                                     // overflow_flag[67], zero_flag[68],
                                     // sign_flag[69], flag_update_mask[73:70],
                                     // divide_error[74], zero fill
);
   import xalu_pkg::*;

   qent_type ent, q_data;
   logic     q_full, q_empty, q_pop;
   rsp_type  rsp;

   // Classification of the incoming request
   xalu_front u_front (
      .req_tuser (req_tuser),
      .req_tdata (req_tdata),
      .ent       (ent)
   );

   // Decoupling queue
   xalu_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_tvalid),
      .push_data (ent),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .pop_data  (q_data)
   );

   assign req_tready = !q_full;

   // Execution pipeline
   xalu_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_data    (q_data),
      .q_pop     (q_pop),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (rsp)
   );

   // Response packing
   assign rsp_tdata = {5'd0, rsp.derr, rsp.fm, rsp.flags[3], rsp.flags[2], rsp.flags[1],
                       rsp.flags[0], rsp.tgt, rsp.hi, rsp.lo};

endmodule

### verif/tb_x86_integer_alu_with_flags.sv
// Self-checking testbench for the x86 integer ALU with flags.
// Drives requests on the req_ stream, predicts every response and checks it
// field by field; depends on xalu_pkg and x86_integer_alu_with_flags.
module tb_x86_integer_alu_with_flags;
   timeunit 1ns;
   timeprecision 1ps;
   import xalu_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 60;

   // Opcodes outside the defined set
   localparam logic [3:0] OP_SPARE_LO = 4'd14;
   localparam logic [3:0] OP_SPARE_HI = 4'd15;

   typedef struct packed {
      logic [3:0]  opcode;
      logic [1:0]  op_size;
      logic [1:0]  src_size;
      logic [31:0] dest_value;
      logic [31:0] src_value;
      logic [31:0] src2_value;
      logic [31:0] acc_low;
      logic [31:0] acc_high;
      logic        carry_in;
   } alu_req_type;

   // Listed from the highest bit down, so that it maps straight onto rsp_tdata.
   typedef struct packed {
      logic        divide_error;
      logic [3:0]  flag_update_mask;
      logic        sign_flag;
      logic        zero_flag;
      logic        overflow_flag;
      logic        carry_flag;
      logic [1:0]  write_target;
      logic [31:0] result_high;
      logic [31:0] result_low;
   } alu_rsp_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [7:0]   req_tuser = '0;
   logic [167:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [79:0]  rsp_tdata;

   alu_rsp_type pending_rsp[$];
   int       error_count = 0;
   int       rsp_count = 0;
   int       req_count = 0;
   int       idle_cycles = 0;
   bit       sink_idle_on = 1'b1;
   bit       source_idle_on = 1'b1;
   bit       hold_sink = 1'b0;

   x86_integer_alu_with_flags dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tuser(req_tuser), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always #6 clock = ~clock;

   // Width in bits of a size code; code three counts as dword.
   function automatic int width_of(input logic [1:0] code);
      return code == 2'd0 ? 8 : (code == 2'd1 ? 16 : 32);
   endfunction

   function automatic logic [63:0] mask_of(input int n);
      return (64'd1 << n) - 64'd1;
   endfunction

   function automatic logic [63:0] sign_ext(input logic [63:0] v, input int n);
      logic [63:0] sb;
      sb = 64'd1 << (n - 1);
      v = v & mask_of(n);
      return (v ^ sb) - sb;
   endfunction

   // Computes the response that the ALU must give for one request.
   function automatic alu_rsp_type predict_alu(input alu_req_type q);
      alu_rsp_type r;
      int          n, sn;
      logic [63:0] m, dst, src, acc, a, b, s, t, p, lo, hi, dh, dvd, qt, rm, lim;
      logic [3:0]  fm;
      logic [3:0]  fl;
      logic        cin, sub, nd, ns, qn, err, f;
      logic [1:0]  tgt;
      n = width_of(q.op_size);
      sn = width_of(q.src_size);
      m = mask_of(n);
      dst = q.dest_value & m;
      src = sign_ext(q.src_value, sn) & m;
      acc = {32'd0, q.acc_low};
      lo = 0; hi = 0; tgt = TGT_NONE; fm = 4'd0; fl = 4'd0; err = 1'b0;
      a = dst; b = src; cin = 1'b0; sub = 1'b0;
      case (q.opcode)
         OP_ADD, OP_SUB, OP_CMP, OP_INC, OP_DEC, OP_NEG, OP_ADC, OP_SBB: begin
            // Add/subtract family shares one adder and one flag rule.
            fm = F_ALL;
            tgt = TGT_DEST;
            case (q.opcode)
               OP_SUB: sub = 1'b1;
               OP_CMP: begin sub = 1'b1; tgt = TGT_NONE; end
               OP_INC: begin b = 1; fm = F_OF | F_ZF | F_SF; end
               OP_DEC: begin b = 1; sub = 1'b1; fm = F_OF | F_ZF | F_SF; end
               OP_NEG: begin a = 0; b = dst; sub = 1'b1; end
               OP_ADC: cin = q.carry_in;
               OP_SBB: begin cin = q.carry_in; sub = 1'b1; end
               default: ;
            endcase
            if (sub) begin
               lo = (a - b - cin) & m;
               fl[0] = (b + cin) > a;
               t = (a ^ b) & (a ^ lo);
               fl[1] = t[n - 1];
            end else begin
               s = a + b + cin;
               lo = s & m;
               fl[0] = s[n];
               t = ~(a ^ b) & (a ^ lo);
               fl[1] = t[n - 1];
            end
            fl[2] = lo == 0;
            fl[3] = lo[n - 1];
         end
         OP_MUL, OP_IMUL1, OP_IMUL2, OP_IMUL3: begin
            case (q.opcode)
               OP_MUL:   begin a = dst; b = acc & m; end
               OP_IMUL1: begin a = sign_ext(dst, n); b = sign_ext(acc, n); end
               OP_IMUL2: begin a = sign_ext(dst, n); b = sign_ext(src, n); end
               default: begin
                  a = sign_ext(q.src_value, n);
                  b = sign_ext(sign_ext(q.src2_value, sn), n);
               end
            endcase
            p = a * b;
            lo = p & m;
            hi = (p >> n) & m;
            f = q.opcode == OP_MUL ? hi != 0 : sign_ext(lo, n) != p;
            fl[0] = f;
            fl[1] = f;
            fm = F_CF | F_OF;
            if (q.opcode == OP_MUL || q.opcode == OP_IMUL1) begin
               tgt = TGT_ACC;
            end else begin
               tgt = TGT_DEST;
               hi = 0;
            end
         end
         OP_DIV, OP_IDIV: begin
            // Dividend is AX for bytes, otherwise DX:AX or EDX:EAX.
            dh = n == 8 ? (acc >> 8) & 64'hFF : {32'd0, q.acc_high} & m;
            dvd = ((dh << n) | (acc & m)) & mask_of(2 * n);
            if (dst == 0) begin
               err = 1'b1;
            end else if (q.opcode == OP_DIV) begin
               qt = dvd / dst;
               rm = dvd % dst;
               if (qt > m) err = 1'b1;
               else begin lo = qt; hi = rm; end
            end else begin
               nd = dh[n - 1];
               ns = dst[n - 1];
               a = nd ? (-dvd) & mask_of(2 * n) : dvd;
               b = ns ? (-dst) & m : dst;
               qt = a / b;
               rm = a % b;
               lim = 64'd1 << (n - 1);
               qn = nd != ns;
               if (qn ? qt > lim : qt >= lim) err = 1'b1;
               else begin
                  lo = (qn ? -qt : qt) & m;
                  hi = (nd ? -rm : rm) & m;
               end
            end
            if (!err) tgt = TGT_ACC;
         end
         default: ;
      endcase
      fl = fl & fm;
      r.result_low = lo[31:0];
      r.result_high = hi[31:0];
      r.write_target = tgt;
      r.carry_flag = fl[0];
      r.overflow_flag = fl[1];
      r.zero_flag = fl[2];
      r.sign_flag = fl[3];
      r.flag_update_mask = fm;
      r.divide_error = err;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
      error_count++;
   endtask

   // Sends one request, idling at random beforehand, and records its prediction.
   task automatic send_request(input alu_req_type q);
      while (source_idle_on && $urandom_range(99) < 9) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= {4'd0, q.opcode};
      req_tdata <= {3'd0, q.carry_in, q.acc_high, q.acc_low, q.src2_value,
                    q.src_value, q.dest_value, q.src_size, q.op_size};
      pending_rsp.push_back(predict_alu(q));
      do @(posedge clock); while (!req_tready);
      req_count++;
   endtask

   // Request with random content and the given opcode.
   function automatic alu_req_type random_request(input logic [3:0] op);
      alu_req_type q;
      q.opcode = op;
      q.op_size = 2'($urandom_range(3));
      q.src_size = 2'($urandom_range(3));
      q.dest_value = $urandom;
      q.src_value = $urandom;
      q.src2_value = $urandom;
      q.acc_low = $urandom;
      q.acc_high = $urandom;
      q.carry_in = 1'($urandom_range(1));
      // Often pick small or edge operands so that carries and overflows happen.
      case ($urandom_range(5))
         0: q.dest_value = $urandom_range(3);
         1: q.dest_value = 32'hFFFF_FFFF - $urandom_range(2);
         2: q.dest_value = 32'h8000_0000 >> (8 * $urandom_range(3));
         default: ;
      endcase
      // Divides: keep the high half small so that most quotients fit.
      if ((op == OP_DIV || op == OP_IDIV) && $urandom_range(3) != 0) begin
         q.acc_high = $urandom_range(3);
         q.acc_low[15:8] = 8'($urandom_range(1));
         if ($urandom_range(1)) begin
            q.acc_high = ~q.acc_high;
            q.acc_low[15:8] = ~q.acc_low[15:8];
         end
      end
      return q;
   endfunction

   function automatic alu_req_type make_request(input logic [3:0] op, input logic [1:0] sz,
                                                input logic [31:0] d, input logic [31:0] s,
                                                input logic [31:0] al,
                                                input logic [31:0] ah);
      alu_req_type q;
      q = '{op, sz, sz, d, s, 32'h0, al, ah, 1'b1};
      return q;
   endfunction

   // Checks each accepted response against the oldest prediction.
   always @(posedge clock) begin
      alu_rsp_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = alu_rsp_type'(rsp_tdata[74:0]);
         rsp_count++;
         if (pending_rsp.size() == 0) begin
            report_mismatch("unexpected response", rsp_tdata[31:0], 32'h0);
         end else begin
            want = pending_rsp.pop_front();
            if (got.result_low !== want.result_low)
               report_mismatch("result_low", got.result_low, want.result_low);
            if (got.result_high !== want.result_high)
               report_mismatch("result_high", got.result_high, want.result_high);
            if (got.write_target !== want.write_target)
               report_mismatch("write_target", got.write_target, want.write_target);
            if (got.carry_flag !== want.carry_flag)
               report_mismatch("carry_flag", got.carry_flag, want.carry_flag);
            if (got.overflow_flag !== want.overflow_flag)
               report_mismatch("overflow_flag", got.overflow_flag, want.overflow_flag);
            if (got.zero_flag !== want.zero_flag)
               report_mismatch("zero_flag", got.zero_flag, want.zero_flag);
            if (got.sign_flag !== want.sign_flag)
               report_mismatch("sign_flag", got.sign_flag, want.sign_flag);
            if (got.flag_update_mask !== want.flag_update_mask)
               report_mismatch("flag_update_mask", got.flag_update_mask,
                               want.flag_update_mask);
            if (got.divide_error !== want.divide_error)
               report_mismatch("divide_error", got.divide_error, want.divide_error);
         end
      end
   end

   // Response side readiness: random stalls, or a long hold-off when asked.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !hold_sink && !(sink_idle_on && $urandom_range(99) < 9);
      end
   end

   // Watchdog on cycles in which nothing is accepted.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (!reset) begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d responses outstanding", pending_rsp.size());
            $display("** x86_integer_alu_with_flags: FAILED **");
            $finish;
         end
      end
   end

   // Extremes of operands, every opcode and every special case.
   task automatic test_directed();
      send_request(make_request(OP_ADD, 2'd0, 32'hFF, 32'h01, 0, 0));
      send_request(make_request(OP_ADD, 2'd1, 32'h7FFF, 32'h0001, 0, 0));
      send_request(make_request(OP_SUB, 2'd2, 32'h0, 32'h1, 0, 0));
      send_request(make_request(OP_CMP, 2'd2, 32'h8000_0000, 32'h1, 0, 0));
      send_request(make_request(OP_INC, 2'd0, 32'h7F, 0, 0, 0));
      send_request(make_request(OP_DEC, 2'd1, 32'h8000, 0, 0, 0));
      send_request(make_request(OP_NEG, 2'd2, 32'h8000_0000, 0, 0, 0));
      send_request(make_request(OP_ADC, 2'd2, 32'hFFFF_FFFF, 32'h0, 0, 0));
      send_request(make_request(OP_SBB, 2'd0, 32'h0, 32'h0, 0, 0));
      send_request(make_request(OP_MUL, 2'd2, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 0));
      send_request(make_request(OP_IMUL1, 2'd0, 32'h80, 0, 32'h80, 0));
      send_request(make_request(OP_IMUL2, 2'd1, 32'hFFFF, 32'hFFFF, 0, 0));
      send_request('{OP_IMUL3, 2'd2, 2'd0, 32'h0, 32'h4000_0000, 32'h80, 0, 0, 1'b0});
      send_request(make_request(OP_DIV, 2'd0, 32'h0, 0, 32'h1234, 0));
      send_request(make_request(OP_DIV, 2'd1, 32'h1, 0, 32'h0, 32'h1));
      send_request(make_request(OP_DIV, 2'd2, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF,
                                32'hFFFF_FFFE));
      send_request(make_request(OP_IDIV, 2'd2, 32'hFFFF_FFFF, 0, 32'h8000_0000,
                                32'hFFFF_FFFF));
      send_request(make_request(OP_IDIV, 2'd0, 32'hFF, 0, 32'h0080, 0));
      send_request(make_request(OP_IDIV, 2'd1, 32'h0007, 0, 32'hFFF9, 32'hFFFF));
      send_request(make_request(OP_ADD, 2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0));
      send_request(make_request(OP_SPARE_LO, 2'd2, 32'h5, 32'h5, 0, 0));
      send_request(make_request(OP_SPARE_HI, 2'd0, 32'h5, 32'h5, 0, 0));
   endtask

   // Random requests over all opcodes, sizes and operands.
   task automatic test_random(input int count);
      for (int i = 0; i < count; i++) begin
         send_request(random_request($urandom_range(99) < 97 ? 4'($urandom_range(13)) :
                                     4'($urandom_range(OP_SPARE_HI, OP_SPARE_LO))));
      end
   endtask

   // Receiver holds off for a long stretch while requests keep coming.
   task automatic test_backpressure();
      fork
         begin
            hold_sink = 1'b1;
            repeat (120) @(posedge clock);
            hold_sink = 1'b0;
         end
         test_random(80);
      join
   endtask

   // Back-to-back traffic with no idling on either side.
   task automatic test_streaming();
      source_idle_on = 1'b0;
      sink_idle_on = 1'b0;
      test_random(200);
      source_idle_on = 1'b1;
      sink_idle_on = 1'b1;
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(300);
      test_backpressure();
      test_streaming();
      test_random(250);
      req_tvalid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Ran %0d requests over all opcodes and sizes, including divide errors,",
               req_count);
      $display("a long receiver hold-off and a stall-free stretch; %0d responses checked.",
               rsp_count);
      if (error_count == 0) begin
         $display("** x86_integer_alu_with_flags: PASSED **");
      end else begin
         $display("** x86_integer_alu_with_flags: FAILED **");
      end
      $finish;
   end
endmodule
